FILE: design/rcfs_pkg.sv
// Shared types and constants for the RC failsafe arming interlock.
package rcfs_pkg;

    // Link phase codes as reported on the result channel.
    typedef enum logic [1:0] {
        PHASE_UP      = 2'd0,
        PHASE_GUARD   = 2'd1,
        PHASE_RECOVER = 2'd2
    } phase_t;

    // Command codes carried by an input item.
    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_ARM    = 2'd1,
        CMD_DISARM = 2'd2
    } cmd_t;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_GUARD_TIME     = 3'd0,
        CFG_RECOVERY_TIME  = 3'd1,
        CFG_LOSS_TIMEOUT   = 3'd2,
        CFG_SWITCH_MAPPED  = 3'd3,
        CFG_WINDOW_LOW     = 3'd4,
        CFG_WINDOW_HIGH    = 3'd5,
        CFG_BATTERY_FLOOR  = 3'd6
    } cfg_idx_t;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned PULSE_W    = 12;
    localparam int unsigned MV_W       = 16;
    localparam int unsigned BLK_W      = 4;

    // Bit positions in the blocker mask.
    localparam int unsigned BLK_NOT_IDLE = 0;
    localparam int unsigned BLK_LOW_BATT = 1;
    localparam int unsigned BLK_RC_LOSS  = 2;
    localparam int unsigned BLK_SWITCH   = 3;

    // Controls from the top level into the link machine.
    typedef struct packed {
        logic update;
        logic link_ok;
        logic armed;
    } link_ctrl_t;

    // Settled phase and disarm request from the link machine.
    typedef struct packed {
        phase_t phase;
        logic   disarm;
    } link_stat_t;

endpackage

FILE: design/rc_failsafe_arm_interlock.sv
// Arming supervisor with RC link failsafe, switch interlock and arm blockers.
//
// Each input item is a supervise tick or an external arm or disarm request
// and yields exactly one result item. An accepted item sits in an input
// register; logic against the supervisor state computes the result into an
// output register and updates the state, so the block takes one item per
// clock cycle while m_ready keeps the output register free, and presents the
// result on the m_ ports from the output register. The
// rate is set by the state feedback of the link machine and armed flag,
// which every item reads and writes in its step. The input side stays open
// while a result waits only as long as the input register is empty.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata; the user
// must write it only while no item is in flight, as the block does not enforce it.
module rc_failsafe_arm_interlock (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [rcfs_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rcfs_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // Input items.
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_cmd,
    input  logic [rcfs_pkg::TIME_W-1:0]         s_now_us,
    input  logic [rcfs_pkg::TIME_W-1:0]         s_frame_stamp_us,
    input  logic [rcfs_pkg::PULSE_W-1:0]        s_switch_pulse_us,
    input  logic                                s_loop_running,
    input  logic [rcfs_pkg::MV_W-1:0]           s_pack_mv,
    // Result items.
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_armed_now,
    output logic [1:0]                          m_link_phase,
    output logic                                m_loss_failsafe,
    output logic [rcfs_pkg::BLK_W-1:0]          m_blocker_mask,
    output logic                                m_warn_tone,
    output logic                                m_stop_motors,
    output logic                                m_reset_controller
);

    // Configuration registers.
    logic [rcfs_pkg::TIME_W-1:0]   guard_time_reg;
    logic [rcfs_pkg::TIME_W-1:0]   recovery_time_reg;
    logic [rcfs_pkg::TIME_W-1:0]   loss_timeout_reg;
    logic                          switch_mapped_reg;
    logic [rcfs_pkg::PULSE_W-1:0]  window_low_reg;
    logic [rcfs_pkg::PULSE_W-1:0]  window_high_reg;
    logic [rcfs_pkg::MV_W-1:0]     battery_floor_reg;

    // Input register.
    logic                          in_valid_reg;
    logic [1:0]                    in_cmd_reg;
    logic [rcfs_pkg::TIME_W-1:0]   in_now_reg;
    logic [rcfs_pkg::TIME_W-1:0]   in_stamp_reg;
    logic [rcfs_pkg::PULSE_W-1:0]  in_pulse_reg;
    logic                          in_running_reg;
    logic [rcfs_pkg::MV_W-1:0]     in_pack_reg;

    // Supervisor state.
    logic                          armed_reg, armed_next;
    logic                          interlock_reg, interlock_next;
    logic                          authority_reg, authority_next;
    logic [rcfs_pkg::BLK_W-1:0]    announced_reg, announced_next;
    logic [rcfs_pkg::BLK_W-1:0]    blocker_reg, blocker_next;

    // Output register.
    logic                          m_valid_reg;
    logic                          m_armed_reg;
    rcfs_pkg::phase_t              m_phase_reg;
    logic [rcfs_pkg::BLK_W-1:0]    m_blocker_reg;
    logic                          m_warn_reg, warn_next;
    logic                          m_stop_reg, stop_next;
    logic                          m_reset_reg, reset_next;

    logic                          s_accept;
    logic                          do_step;
    logic                          is_tick_run;

    // Link evaluation signals.
    logic [rcfs_pkg::TIME_W-1:0]   frame_age;
    logic                          seen;
    logic                          fresh;
    logic                          link_ok;
    logic                          live;
    logic                          sw_in_range;
    logic [rcfs_pkg::BLK_W-1:0]    standing;
    logic                          settle_disarm;
    logic                          armed_mid;
    logic                          interlock_mid;
    logic                          interlock_sw;
    logic [rcfs_pkg::BLK_W-1:0]    blk_sup;

    rcfs_pkg::link_ctrl_t          link_ctrl;
    rcfs_pkg::link_stat_t          link_stat;

    // Handshake: the input register advances whenever the output register
    // is empty or being drained.
    assign do_step  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || do_step;
    assign s_accept = s_valid && s_ready;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            guard_time_reg    <= '0;
            recovery_time_reg <= '0;
            loss_timeout_reg  <= '0;
            switch_mapped_reg <= 1'b0;
            window_low_reg    <= '0;
            window_high_reg   <= '0;
            battery_floor_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                rcfs_pkg::CFG_GUARD_TIME:    guard_time_reg    <= cfg_wdata;
                rcfs_pkg::CFG_RECOVERY_TIME: recovery_time_reg <= cfg_wdata;
                rcfs_pkg::CFG_LOSS_TIMEOUT:  loss_timeout_reg  <= cfg_wdata;
                rcfs_pkg::CFG_SWITCH_MAPPED: switch_mapped_reg <= cfg_wdata[0];
                rcfs_pkg::CFG_WINDOW_LOW:    window_low_reg    <= cfg_wdata[rcfs_pkg::PULSE_W-1:0];
                rcfs_pkg::CFG_WINDOW_HIGH:   window_high_reg   <= cfg_wdata[rcfs_pkg::PULSE_W-1:0];
                rcfs_pkg::CFG_BATTERY_FLOOR: battery_floor_reg <= cfg_wdata[rcfs_pkg::MV_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (do_step) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_cmd_reg     <= s_cmd;
            in_now_reg     <= s_now_us;
            in_stamp_reg   <= s_frame_stamp_us;
            in_pulse_reg   <= s_switch_pulse_us;
            in_running_reg <= s_loop_running;
            in_pack_reg    <= s_pack_mv;
        end
    end

    // Link health and arm switch decode. A stamp of zero is a healthy link
    // that is not fresh, so the switch is ignored.
    assign frame_age   = in_now_reg - in_stamp_reg;
    assign seen        = in_stamp_reg != '0;
    assign fresh       = seen && (frame_age < loss_timeout_reg);
    assign link_ok     = !seen || fresh;
    assign live        = switch_mapped_reg && fresh;
    assign sw_in_range = live && (in_pulse_reg >= window_low_reg)
                              && (in_pulse_reg <= window_high_reg);

    // Blockers that do not depend on the link machine.
    always_comb begin
        standing = '0;
        standing[rcfs_pkg::BLK_NOT_IDLE] = !(in_running_reg && !armed_reg);
        standing[rcfs_pkg::BLK_LOW_BATT] = (battery_floor_reg != '0)
                                        && (in_pack_reg < battery_floor_reg);
    end

    // The link machine runs only on a tick with the control loop running.
    assign is_tick_run = (in_cmd_reg == rcfs_pkg::CMD_TICK) && in_running_reg;

    always_comb begin
        link_ctrl.update  = do_step && is_tick_run;
        link_ctrl.link_ok = link_ok;
        link_ctrl.armed   = armed_reg;
    end

    rcfs_link u_link (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .ctrl             (link_ctrl),
        .now_us           (in_now_reg),
        .guard_time_us    (guard_time_reg),
        .recovery_time_us (recovery_time_reg),
        .stat             (link_stat)
    );

    // State after the link machine has settled, then the switch interlock.
    assign settle_disarm = link_stat.disarm && armed_reg;
    assign armed_mid     = armed_reg && !link_stat.disarm;
    assign interlock_mid = interlock_reg || settle_disarm;
    assign interlock_sw  = sw_in_range ? interlock_mid : (live ? 1'b0 : interlock_mid);

    always_comb begin
        blk_sup = standing;
        blk_sup[rcfs_pkg::BLK_RC_LOSS] = link_stat.phase != rcfs_pkg::PHASE_UP;
        blk_sup[rcfs_pkg::BLK_SWITCH]  = live && interlock_sw;
    end

    // Arming decisions for one item.
    always_comb begin
        armed_next     = armed_reg;
        interlock_next = interlock_reg;
        authority_next = authority_reg;
        announced_next = announced_reg;
        blocker_next   = blocker_reg;
        warn_next      = 1'b0;
        stop_next      = 1'b0;
        reset_next     = 1'b0;
        case (in_cmd_reg)
            rcfs_pkg::CMD_TICK: begin
                if (!in_running_reg) begin
                    blocker_next = standing;
                end else begin
                    blocker_next   = blk_sup;
                    armed_next     = armed_mid;
                    interlock_next = interlock_sw;
                    authority_next = authority_reg || sw_in_range;
                    stop_next      = settle_disarm;
                    reset_next     = settle_disarm;
                    if (!live) begin
                        announced_next = '0;
                    end else if (!sw_in_range) begin
                        // Switch out of the window disarms once it has had authority.
                        announced_next = '0;
                        if (authority_reg && armed_mid) begin
                            armed_next     = 1'b0;
                            interlock_next = 1'b1;
                            stop_next      = 1'b1;
                            reset_next     = 1'b1;
                        end
                    end else if (!armed_mid) begin
                        if (blk_sup == '0) begin
                            armed_next = 1'b1;
                            reset_next = 1'b1;
                        end else if (blk_sup != announced_reg) begin
                            // Sound the tone once for each new set of refusals.
                            announced_next = blk_sup;
                            warn_next      = 1'b1;
                        end
                    end
                end
            end
            rcfs_pkg::CMD_ARM: begin
                if (!armed_reg) begin
                    if (blocker_reg != '0) begin
                        warn_next = 1'b1;
                    end else begin
                        armed_next = 1'b1;
                        reset_next = 1'b1;
                    end
                end
            end
            rcfs_pkg::CMD_DISARM: begin
                if (armed_reg) begin
                    armed_next     = 1'b0;
                    interlock_next = 1'b1;
                    stop_next      = 1'b1;
                    reset_next     = 1'b1;
                end
            end
            default: begin
                armed_next = armed_reg;
            end
        endcase
    end

    // Supervisor state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg     <= 1'b0;
            interlock_reg <= 1'b1;
            authority_reg <= 1'b0;
            announced_reg <= '0;
            blocker_reg   <= rcfs_pkg::BLK_W'(1) << rcfs_pkg::BLK_NOT_IDLE;
        end else if (do_step) begin
            armed_reg     <= armed_next;
            interlock_reg <= interlock_next;
            authority_reg <= authority_next;
            announced_reg <= announced_next;
            blocker_reg   <= blocker_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_step) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_step) begin
            m_armed_reg   <= armed_next;
            m_phase_reg   <= link_stat.phase;
            m_blocker_reg <= blocker_next;
            m_warn_reg    <= warn_next;
            m_stop_reg    <= stop_next;
            m_reset_reg   <= reset_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_armed_now        = m_armed_reg;
    assign m_link_phase       = m_phase_reg;
    assign m_loss_failsafe    = m_phase_reg != rcfs_pkg::PHASE_UP;
    assign m_blocker_mask     = m_blocker_reg;
    assign m_warn_tone        = m_warn_reg;
    assign m_stop_motors      = m_stop_reg;
    assign m_reset_controller = m_reset_reg;

    // A stop pulse always comes with a controller reset and a disarmed vehicle.
    a_stop_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_stop_reg) |-> (m_reset_reg && !m_armed_reg))
        else $error("stop_motors without controller reset or while armed");

    // Arming is only ever taken together with a controller reset result.
    a_arm_pulses_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        (armed_reg && !$past(armed_reg)) |-> (m_valid_reg && m_reset_reg))
        else $error("armed flag rose without a controller reset");

    // The reported armed flag tracks the state register after each item.
    a_armed_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        do_step |=> (m_armed_reg == armed_reg))
        else $error("result armed flag differs from state");

    // Whenever the link is not up the rc loss blocker must be set after a running tick.
    a_loss_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_step && is_tick_run) |=> (m_blocker_reg[rcfs_pkg::BLK_RC_LOSS]
                                      == (m_phase_reg != rcfs_pkg::PHASE_UP)))
        else $error("rc loss blocker disagrees with link phase");

endmodule

FILE: design/rcfs_link.sv
// RC link phase machine: up, guard and recovering, settled once per tick.
module rcfs_link (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  rcfs_pkg::link_ctrl_t            ctrl,
    input  logic [rcfs_pkg::TIME_W-1:0]     now_us,
    input  logic [rcfs_pkg::TIME_W-1:0]     guard_time_us,
    input  logic [rcfs_pkg::TIME_W-1:0]     recovery_time_us,
    output rcfs_pkg::link_stat_t            stat
);

    rcfs_pkg::phase_t              phase_reg, phase_next;
    logic [rcfs_pkg::TIME_W-1:0]   entry_reg, entry_next;
    logic [rcfs_pkg::TIME_W-1:0]   clean_reg, clean_next;
    logic [rcfs_pkg::TIME_W-1:0]   guard_age;
    logic [rcfs_pkg::TIME_W-1:0]   clean_age;
    logic                          guard_done;
    logic                          recovery_done;
    logic                          disarm;

    // Wrapping elapsed times for the guard and recovery timers.
    assign guard_age     = now_us - entry_reg;
    assign clean_age     = now_us - clean_reg;
    assign guard_done    = guard_age >= guard_time_us;
    assign recovery_done = clean_age >= recovery_time_us;

    // Settled outcome of one tick. A loss seen while up falls through guard
    // into recovery in the same tick when the guard cannot hold (vehicle
    // disarmed or zero guard time); a return to up from guard or recovery
    // stops there because the link is healthy.
    always_comb begin
        phase_next = phase_reg;
        entry_next = entry_reg;
        clean_next = clean_reg;
        disarm     = 1'b0;
        case (phase_reg)
            rcfs_pkg::PHASE_UP: begin
                if (!ctrl.link_ok) begin
                    entry_next = now_us;
                    if (!ctrl.armed || guard_time_us == '0) begin
                        disarm     = 1'b1;
                        clean_next = '0;
                        phase_next = rcfs_pkg::PHASE_RECOVER;
                    end else begin
                        phase_next = rcfs_pkg::PHASE_GUARD;
                    end
                end
            end
            rcfs_pkg::PHASE_GUARD: begin
                if (ctrl.link_ok) begin
                    phase_next = rcfs_pkg::PHASE_UP;
                    entry_next = now_us;
                end else if (!ctrl.armed || guard_done) begin
                    disarm     = 1'b1;
                    clean_next = '0;
                    phase_next = rcfs_pkg::PHASE_RECOVER;
                    entry_next = now_us;
                end
            end
            rcfs_pkg::PHASE_RECOVER: begin
                if (!ctrl.link_ok) begin
                    clean_next = '0;
                end else if (clean_reg == '0) begin
                    // Zero marks the clean timer as not started.
                    clean_next = (now_us == '0) ? {{(rcfs_pkg::TIME_W-1){1'b0}}, 1'b1}
                                                : now_us;
                end else if (recovery_done) begin
                    phase_next = rcfs_pkg::PHASE_UP;
                    entry_next = now_us;
                end
            end
            default: begin
                phase_next = phase_reg;
            end
        endcase
    end

    // The settled phase is shown only for an item that runs the machine.
    always_comb begin
        stat.phase  = ctrl.update ? phase_next : phase_reg;
        stat.disarm = ctrl.update & disarm;
    end

    // Phase and timer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= rcfs_pkg::PHASE_UP;
            entry_reg <= '0;
            clean_reg <= '0;
        end else if (ctrl.update) begin
            phase_reg <= phase_next;
            entry_reg <= entry_next;
            clean_reg <= clean_next;
        end
    end

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the RC failsafe arming interlock.
module testbench;

    localparam int unsigned CYCLE_LIMIT       = 200_000;
    localparam int unsigned SETTLE_STEPS      = 3;
    localparam int unsigned RANDOM_SETTINGS   = 12;
    localparam int unsigned ITEMS_PER_SETTING = 130;
    // The command code that the block must ignore.
    localparam logic [1:0]  CMD_NONE          = 2'd3;

    // One input item as driven on the s_ ports.
    typedef struct packed {
        logic [1:0]                   cmd;
        logic [rcfs_pkg::TIME_W-1:0]  now;
        logic [rcfs_pkg::TIME_W-1:0]  stamp;
        logic [rcfs_pkg::PULSE_W-1:0] pulse;
        logic                         running;
        logic [rcfs_pkg::MV_W-1:0]    pack;
    } item_t;

    // One result item as seen on the m_ ports.
    typedef struct packed {
        logic                       armed;
        rcfs_pkg::phase_t           phase;
        logic                       failsafe;
        logic [rcfs_pkg::BLK_W-1:0] blockers;
        logic                       tone;
        logic                       stop;
        logic                       ctl_reset;
    } status_t;

    logic                            aclk;
    logic                            aresetn;
    logic                            cfg_we;
    logic [rcfs_pkg::CFG_ADDR_W-1:0] cfg_addr;
    logic [rcfs_pkg::CFG_DATA_W-1:0] cfg_wdata;
    logic                            s_valid;
    logic                            s_ready;
    logic [1:0]                      s_cmd;
    logic [rcfs_pkg::TIME_W-1:0]     s_now_us;
    logic [rcfs_pkg::TIME_W-1:0]     s_frame_stamp_us;
    logic [rcfs_pkg::PULSE_W-1:0]    s_switch_pulse_us;
    logic                            s_loop_running;
    logic [rcfs_pkg::MV_W-1:0]       s_pack_mv;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_armed_now;
    logic [1:0]                      m_link_phase;
    logic                            m_loss_failsafe;
    logic [rcfs_pkg::BLK_W-1:0]      m_blocker_mask;
    logic                            m_warn_tone;
    logic                            m_stop_motors;
    logic                            m_reset_controller;

    rc_failsafe_arm_interlock i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_we             (cfg_we),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_cmd              (s_cmd),
        .s_now_us           (s_now_us),
        .s_frame_stamp_us   (s_frame_stamp_us),
        .s_switch_pulse_us  (s_switch_pulse_us),
        .s_loop_running     (s_loop_running),
        .s_pack_mv          (s_pack_mv),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_armed_now        (m_armed_now),
        .m_link_phase       (m_link_phase),
        .m_loss_failsafe    (m_loss_failsafe),
        .m_blocker_mask     (m_blocker_mask),
        .m_warn_tone        (m_warn_tone),
        .m_stop_motors      (m_stop_motors),
        .m_reset_controller (m_reset_controller)
    );

    // Configuration as last written to the block.
    logic [31:0]      cfg_guard_us;
    logic [31:0]      cfg_recovery_us;
    logic [31:0]      cfg_loss_us;
    logic             cfg_mapped;
    logic [11:0]      cfg_win_lo;
    logic [11:0]      cfg_win_hi;
    logic [15:0]      cfg_floor_mv;

    // Supervisor state and per-item pulses of the predictor.
    logic                       sup_armed;
    rcfs_pkg::phase_t           sup_phase;
    logic [31:0]                sup_entry_us;
    logic [31:0]                sup_clean_since_us;
    logic                       sup_interlock;
    logic                       sup_authority;
    logic [rcfs_pkg::BLK_W-1:0] sup_announced;
    logic [rcfs_pkg::BLK_W-1:0] sup_blockers;
    logic                       tone_pulse;
    logic                       stop_pulse;
    logic                       reset_pulse;

    status_t          pending_status[$];
    status_t          oldest;
    int unsigned      error_count;
    int unsigned      cycle_count;
    bit               gaps_on;
    bit               stalls_on;

    // Scenario state for the random traffic.
    logic [31:0]      clock_us;
    logic [31:0]      last_frame_us;
    logic [31:0]      step_max_us;
    bit               link_down;
    bit               switch_on;

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Run limit in case the block stops moving.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Bring the predictor to its reset state.
    function automatic void reset_model();
        cfg_guard_us       = '0;
        cfg_recovery_us    = '0;
        cfg_loss_us        = '0;
        cfg_mapped         = 1'b0;
        cfg_win_lo         = '0;
        cfg_win_hi         = '0;
        cfg_floor_mv       = '0;
        sup_armed          = 1'b0;
        sup_phase          = rcfs_pkg::PHASE_UP;
        sup_entry_us       = '0;
        sup_clean_since_us = '0;
        sup_interlock      = 1'b1;
        sup_authority      = 1'b0;
        sup_announced      = '0;
        sup_blockers       = 4'b0001;
    endfunction

    // An arm or disarm request, refused with a tone while blockers stand.
    function automatic void request_arm(input logic want);
        if (want == sup_armed)
            return;
        if (want && sup_blockers != '0) begin
            tone_pulse = 1'b1;
            return;
        end
        reset_pulse = 1'b1;
        if (!want) begin
            sup_interlock = 1'b1;
            sup_armed     = 1'b0;
            stop_pulse    = 1'b1;
        end else begin
            sup_armed = 1'b1;
        end
    endfunction

    // Link phase machine, run until it holds still or three moves are made.
    function automatic void settle_link(input logic [31:0] now, input logic link_ok);
        rcfs_pkg::phase_t prior;
        logic [31:0]      elapsed;
        logic             settled;
        settled = 1'b0;
        for (int step = 0; step < SETTLE_STEPS; step++) begin
            if (!settled) begin
                prior = sup_phase;
                case (sup_phase)
                    rcfs_pkg::PHASE_UP: begin
                        if (!link_ok)
                            sup_phase = rcfs_pkg::PHASE_GUARD;
                    end
                    rcfs_pkg::PHASE_GUARD: begin
                        elapsed = now - sup_entry_us;
                        if (link_ok) begin
                            sup_phase = rcfs_pkg::PHASE_UP;
                        end else if (!sup_armed || elapsed >= cfg_guard_us) begin
                            request_arm(1'b0);
                            sup_clean_since_us = '0;
                            sup_phase          = rcfs_pkg::PHASE_RECOVER;
                        end
                    end
                    default: begin
                        elapsed = now - sup_clean_since_us;
                        if (!link_ok) begin
                            sup_clean_since_us = '0;
                        end else if (sup_clean_since_us == '0) begin
                            sup_clean_since_us = (now == '0) ? 32'd1 : now;
                        end else if (elapsed >= cfg_recovery_us) begin
                            sup_phase = rcfs_pkg::PHASE_UP;
                        end
                    end
                endcase
                if (sup_phase == prior)
                    settled = 1'b1;
                else
                    sup_entry_us = now;
            end
        end
    endfunction

    // Link, switch and blocker evaluation of a tick with the loop running.
    function automatic void supervise_link(input item_t it,
                                           input logic [rcfs_pkg::BLK_W-1:0] standing);
        logic [31:0]                age;
        logic                       seen;
        logic                       fresh;
        logic                       live;
        logic                       sw_in_range;
        logic [rcfs_pkg::BLK_W-1:0] blk;
        seen  = it.stamp != '0;
        age   = it.now - it.stamp;
        fresh = seen && age < cfg_loss_us;
        live  = cfg_mapped && fresh;
        settle_link(it.now, !seen || fresh);

        sw_in_range = live && it.pulse >= cfg_win_lo && it.pulse <= cfg_win_hi;
        if (sw_in_range)
            sup_authority = 1'b1;
        else if (live)
            sup_interlock = 1'b0;

        blk = standing;
        if (sup_phase != rcfs_pkg::PHASE_UP)
            blk[rcfs_pkg::BLK_RC_LOSS] = 1'b1;
        if (live && sup_interlock)
            blk[rcfs_pkg::BLK_SWITCH] = 1'b1;
        sup_blockers = blk;

        // Switch action: disarm on leaving the window, arm or warn inside it.
        if (!live) begin
            sup_announced = '0;
        end else if (!sw_in_range) begin
            sup_announced = '0;
            if (sup_authority && sup_armed)
                request_arm(1'b0);
        end else if (!sup_armed) begin
            if (blk == '0) begin
                request_arm(1'b1);
            end else if (blk != sup_announced) begin
                sup_announced = blk;
                tone_pulse    = 1'b1;
            end
        end
    endfunction

    // Expected result of one accepted item; updates the predictor state.
    function automatic status_t supervise_item(input item_t it);
        status_t                    st;
        logic [rcfs_pkg::BLK_W-1:0] standing;
        tone_pulse  = 1'b0;
        stop_pulse  = 1'b0;
        reset_pulse = 1'b0;
        case (it.cmd)
            rcfs_pkg::CMD_TICK: begin
                standing = '0;
                if (!it.running || sup_armed)
                    standing[rcfs_pkg::BLK_NOT_IDLE] = 1'b1;
                if (cfg_floor_mv != '0 && it.pack < cfg_floor_mv)
                    standing[rcfs_pkg::BLK_LOW_BATT] = 1'b1;
                if (!it.running)
                    sup_blockers = standing;
                else
                    supervise_link(it, standing);
            end
            rcfs_pkg::CMD_ARM: begin
                request_arm(1'b1);
            end
            rcfs_pkg::CMD_DISARM: begin
                request_arm(1'b0);
            end
            default: begin
            end
        endcase
        st.armed     = sup_armed;
        st.phase     = sup_phase;
        st.failsafe  = sup_phase != rcfs_pkg::PHASE_UP;
        st.blockers  = sup_blockers;
        st.tone      = tone_pulse;
        st.stop      = stop_pulse;
        st.ctl_reset = reset_pulse;
        return st;
    endfunction

    function automatic void compare_field(input string field, input logic [3:0] want,
                                          input logic [3:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Compare each accepted result with the oldest expected status.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t: result item arrived with none expected", $time);
                error_count++;
            end else begin
                oldest = pending_status.pop_front();
                compare_field("armed_now", 4'(oldest.armed), 4'(m_armed_now));
                compare_field("link_phase", 4'(oldest.phase), 4'(m_link_phase));
                compare_field("loss_failsafe", 4'(oldest.failsafe), 4'(m_loss_failsafe));
                compare_field("blocker_mask", oldest.blockers, m_blocker_mask);
                compare_field("warn_tone", 4'(oldest.tone), 4'(m_warn_tone));
                compare_field("stop_motors", 4'(oldest.stop), 4'(m_stop_motors));
                compare_field("reset_controller", 4'(oldest.ctl_reset),
                              4'(m_reset_controller));
            end
        end
    end

    // Result side: a random stall before each result item when enabled.
    initial begin : result_sink
        int unsigned hold;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            hold = stalls_on ? $urandom_range(0, 4) : 0;
            if (hold != 0) begin
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
        end
    end

    function automatic item_t make_item(input logic [1:0] cmd, input logic [31:0] now,
                                        input logic [31:0] stamp, input logic [11:0] pulse,
                                        input logic running, input logic [15:0] pack);
        item_t it;
        it.cmd     = cmd;
        it.now     = now;
        it.stamp   = stamp;
        it.pulse   = pulse;
        it.running = running;
        it.pack    = pack;
        return it;
    endfunction

    // Offer one item after an optional gap and record its expected result.
    task automatic send_item(input item_t it);
        int unsigned gap;
        gap = gaps_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid           <= 1'b1;
        s_cmd             <= it.cmd;
        s_now_us          <= it.now;
        s_frame_stamp_us  <= it.stamp;
        s_switch_pulse_us <= it.pulse;
        s_loop_running    <= it.running;
        s_pack_mv         <= it.pack;
        do @(posedge aclk); while (!s_ready);
        pending_status.push_back(supervise_item(it));
    endtask

    // Stop offering items and wait until every result has come back.
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input rcfs_pkg::cfg_idx_t idx, input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        case (idx)
            rcfs_pkg::CFG_GUARD_TIME:    cfg_guard_us    = value;
            rcfs_pkg::CFG_RECOVERY_TIME: cfg_recovery_us = value;
            rcfs_pkg::CFG_LOSS_TIMEOUT:  cfg_loss_us     = value;
            rcfs_pkg::CFG_SWITCH_MAPPED: cfg_mapped      = value[0];
            rcfs_pkg::CFG_WINDOW_LOW:    cfg_win_lo      = value[11:0];
            rcfs_pkg::CFG_WINDOW_HIGH:   cfg_win_hi      = value[11:0];
            rcfs_pkg::CFG_BATTERY_FLOOR: cfg_floor_mv    = value[15:0];
            default: begin
            end
        endcase
    endtask

    // Write the whole register set once the block has gone idle.
    task automatic apply_config(input logic [31:0] guard, input logic [31:0] recovery,
                                input logic [31:0] loss, input logic mapped,
                                input logic [11:0] lo, input logic [11:0] hi,
                                input logic [15:0] floor_mv);
        settle_idle();
        write_reg(rcfs_pkg::CFG_GUARD_TIME, guard);
        write_reg(rcfs_pkg::CFG_RECOVERY_TIME, recovery);
        write_reg(rcfs_pkg::CFG_LOSS_TIMEOUT, loss);
        write_reg(rcfs_pkg::CFG_SWITCH_MAPPED, {31'd0, mapped});
        write_reg(rcfs_pkg::CFG_WINDOW_LOW, {20'd0, lo});
        write_reg(rcfs_pkg::CFG_WINDOW_HIGH, {20'd0, hi});
        write_reg(rcfs_pkg::CFG_BATTERY_FLOOR, {16'd0, floor_mv});
        cfg_we <= 1'b0;
    endtask

    // Reset defaults: stopped loop, ignored command, refused, redundant and accepted requests.
    task automatic test_reset_state();
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd0, 32'd0, 12'd0, 1'b0, 16'd0));
        send_item(make_item(CMD_NONE, '1, '1, '1, 1'b1, '1));
        send_item(make_item(rcfs_pkg::CMD_ARM, 32'd0, 32'd0, 12'd0, 1'b1, 16'd0));
        send_item(make_item(rcfs_pkg::CMD_DISARM, 32'd0, 32'd0, 12'd0, 1'b1, 16'd0));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd0, 32'd0, 12'd0, 1'b1, 16'd0));
        send_item(make_item(rcfs_pkg::CMD_ARM, 32'd0, 32'd0, 12'd0, 1'b1, 16'd0));
        send_item(make_item(rcfs_pkg::CMD_ARM, 32'd0, 32'd0, 12'd0, 1'b1, 16'd0));
        send_item(make_item(rcfs_pkg::CMD_DISARM, 32'd0, 32'd0, 12'd0, 1'b1, 16'd0));
    endtask

    // Arm switch: uncycled refusal with one tone, cycling, low battery, arm, disarm.
    task automatic test_switch_arming();
        apply_config(32'd500, 32'd300, 32'd1000, 1'b1, 12'd1000, 12'd2000, 16'd11000);
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd5000, 32'd4900, 12'd1500, 1'b1,
                            16'd12000));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd5010, 32'd4900, 12'd1500, 1'b1,
                            16'd12000));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd5020, 32'd4900, 12'd0, 1'b1,
                            16'd12000));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd5030, 32'd4900, 12'd4095, 1'b1,
                            16'd0));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd5040, 32'd4900, 12'd1500, 1'b1,
                            16'hFFFF));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd5050, 32'd4900, 12'd2001, 1'b1,
                            16'hFFFF));
    endtask

    // Link loss: guard timeout disarms, recovery from a never-seen stamp at
    // time zero, and time stamps that wrap.
    task automatic test_link_loss();
        apply_config(32'd500, 32'd300, 32'd1000, 1'b1, 12'd1000, 12'd2000, 16'd0);
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd100, 32'd50, 12'd3000, 1'b1,
                            16'd12000));
        send_item(make_item(rcfs_pkg::CMD_ARM, 32'd100, 32'd50, 12'd3000, 1'b1,
                            16'd12000));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd2000, 32'd50, 12'd3000, 1'b1,
                            16'd12000));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd2600, 32'd50, 12'd3000, 1'b1,
                            16'd12000));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd0, 32'd0, 12'd3000, 1'b1,
                            16'd12000));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd400, 32'd350, 12'd3000, 1'b1,
                            16'd12000));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'hFFFF_FFFF, 32'hFFFF_FF00, 12'd3000,
                            1'b1, 16'd12000));
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'h0000_0010, 32'hFFFF_FF00, 12'd3000,
                            1'b1, 16'd12000));
    endtask

    // A window whose low bound lies above its high bound holds no pulse.
    task automatic test_empty_window();
        apply_config(32'd0, 32'd0, 32'd1000, 1'b1, 12'd4095, 12'd0, 16'd0);
        send_item(make_item(rcfs_pkg::CMD_TICK, 32'd9000, 32'd8990, 12'd4095, 1'b1,
                            16'd12000));
    endtask

    // Guard and recovery times: mostly moderate, sometimes the extremes.
    function automatic logic [31:0] draw_period();
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return '1;
        return $urandom_range(0, 8000);
    endfunction

    // A random item out of a flight scenario: time moves on, the link drops
    // out and comes back, and the switch is flipped now and then.
    function automatic item_t draw_item();
        item_t       it;
        int unsigned roll;
        logic [31:0] age_span;
        roll = $urandom_range(0, 99);
        clock_us = clock_us + $urandom_range(0, step_max_us);
        if (link_down) begin
            if ($urandom_range(0, 99) < 10)
                link_down = 1'b0;
        end else if ($urandom_range(0, 99) < 5) begin
            link_down = 1'b1;
        end
        age_span = (cfg_loss_us == '0) ? '0 : cfg_loss_us - 1;
        if (age_span > 32'd4000)
            age_span = 32'd4000;
        if (!link_down)
            last_frame_us = clock_us - $urandom_range(0, age_span);
        if ($urandom_range(0, 99) < 10)
            switch_on = !switch_on;

        it.cmd = rcfs_pkg::CMD_TICK;
        if (roll < 8)
            it.cmd = rcfs_pkg::CMD_ARM;
        else if (roll < 16)
            it.cmd = rcfs_pkg::CMD_DISARM;
        else if (roll < 19)
            it.cmd = CMD_NONE;
        it.now   = clock_us;
        it.stamp = last_frame_us;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            it.stamp = '0;
        else if (roll < 10)
            it.stamp = $urandom;

        if (switch_on)
            it.pulse = 12'($urandom_range(cfg_win_lo, cfg_win_hi));
        else if (cfg_win_lo != '0)
            it.pulse = 12'($urandom_range(0, cfg_win_lo - 1));
        else if (cfg_win_hi != 12'hFFF)
            it.pulse = 12'($urandom_range(cfg_win_hi + 1, 4095));
        else
            it.pulse = 12'($urandom);
        if ($urandom_range(0, 99) < 5)
            it.pulse = 12'($urandom);

        it.running = $urandom_range(0, 99) < 92;
        if (cfg_floor_mv == '0 || $urandom_range(0, 99) < 12)
            it.pack = 16'($urandom);
        else
            it.pack = 16'($urandom_range(cfg_floor_mv, 16'hFFFF));

        // Occasional noise with every field drawn at random.
        if ($urandom_range(0, 99) < 4) begin
            it.now     = $urandom;
            it.stamp   = $urandom;
            it.pulse   = 12'($urandom);
            it.pack    = 16'($urandom);
            it.running = 1'($urandom_range(0, 1));
        end
        return it;
    endfunction

    // Random traffic over many settings, the first two at the register extremes.
    task automatic test_random_settings();
        logic [31:0] guard;
        logic [31:0] recovery;
        logic [31:0] loss;
        logic        mapped;
        logic [11:0] lo;
        logic [11:0] hi;
        logic [15:0] floor_mv;
        int unsigned roll;
        for (int setting = 0; setting < RANDOM_SETTINGS; setting++) begin
            if (setting == 0) begin
                guard = '1; recovery = '1; loss = '1; mapped = 1'b1;
                lo = '1; hi = '1; floor_mv = '1;
            end else if (setting == 1) begin
                guard = '0; recovery = '0; loss = '0; mapped = 1'b0;
                lo = '0; hi = '0; floor_mv = '0;
            end else begin
                guard    = draw_period();
                recovery = draw_period();
                roll     = $urandom_range(0, 19);
                loss     = (roll == 0) ? 32'd0 : (roll == 1) ? '1 : $urandom_range(500, 3000);
                mapped   = $urandom_range(0, 99) < 85;
                roll     = $urandom_range(0, 9);
                if (roll == 0) begin
                    hi = 12'($urandom_range(0, 4000));
                    lo = 12'(hi + $urandom_range(1, 4095 - hi));
                end else if (roll == 1) begin
                    lo = '0;
                    hi = '1;
                end else begin
                    lo = 12'($urandom_range(800, 1500));
                    hi = 12'(lo + $urandom_range(0, 600));
                end
                roll     = $urandom_range(0, 9);
                floor_mv = (roll < 2) ? 16'd0 : (roll == 2) ? '1
                                              : 16'($urandom_range(9000, 13000));
            end
            apply_config(guard, recovery, loss, mapped, lo, hi, floor_mv);

            // Start time: anywhere, just short of the wrap, or near zero.
            roll = $urandom_range(0, 3);
            if (roll == 0)
                clock_us = 32'hFFFF_FFFF - $urandom_range(0, 20000);
            else if (roll == 1)
                clock_us = $urandom_range(0, 1000);
            else
                clock_us = $urandom;
            last_frame_us = clock_us;
            link_down     = 1'b0;
            switch_on     = 1'b0;
            step_max_us   = $urandom_range(100, 1500);

            roll      = $urandom_range(0, 3);
            gaps_on   = roll[0];
            stalls_on = roll[1];
            for (int n = 0; n < ITEMS_PER_SETTING; n++)
                send_item(draw_item());
        end
        gaps_on   = 1'b1;
        stalls_on = 1'b1;
    endtask

    // Reset, then the tests in turn, then the verdict.
    initial begin : run
        aresetn           = 1'b0;
        cfg_we            = 1'b0;
        cfg_addr          = rcfs_pkg::CFG_GUARD_TIME;
        cfg_wdata         = '0;
        s_valid           = 1'b0;
        s_cmd             = rcfs_pkg::CMD_TICK;
        s_now_us          = '0;
        s_frame_stamp_us  = '0;
        s_switch_pulse_us = '0;
        s_loop_running    = 1'b0;
        s_pack_mv         = '0;
        error_count       = 0;
        cycle_count       = 0;
        gaps_on           = 1'b1;
        stalls_on         = 1'b1;
        reset_model();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_switch_arming();
        test_link_loss();
        test_empty_window();
        test_random_settings();

        settle_idle();
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: rc_failsafe_arm_interlock.f
design/rcfs_pkg.sv
design/rcfs_link.sv
design/rc_failsafe_arm_interlock.sv
test/testbench.sv
